// ----- hdl/bbr_pkg.sv -----
package bbr_pkg;

  // line store geometry
  localparam int MaxWidth = 2048;
  localparam int ColW     = $clog2(MaxWidth);

  // register widths
  localparam int ImgWidthW  = 12;
  localparam int ImgHeightW = 16;
  localparam int CfgDataW   = (ImgWidthW > ImgHeightW) ? ImgWidthW : ImgHeightW;
  localparam int CfgIdxW    = 1;

  // pixel and window geometry
  localparam int ChanW   = 8;
  localparam int NumChan = 3;
  localparam int PixW    = ChanW * NumChan;
  localparam int WinN    = 5;
  localparam int NumLine = WinN - 1;
  localparam int MinDim  = WinN;

  // sums over one window column and over the whole window
  localparam int ColSumW = $clog2(WinN * 255 + 1);
  localparam int SumW    = $clog2(WinN * WinN * 255 + 1);

  // rounded mean: (sum + 12) / 25 as multiply by reciprocal
  localparam int RoundAdd   = (WinN * WinN) / 2;
  localparam int RecipShift = 17;
  localparam int RecipMul   = ((1 << RecipShift) + WinN * WinN - 1) / (WinN * WinN);
  localparam int RecipMulW  = $clog2(RecipMul + 1);
  localparam int ProdW      = SumW + RecipMulW;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // markers that travel with a pixel through the pipeline
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } bbr_flag_t;

endpackage

// ----- hdl/bbr_pix_if.sv -----
interface bbr_pix_if;
  logic                      valid;
  logic                      ready;
  logic                      frame_start;
  logic [bbr_pkg::ChanW-1:0] blue_in;
  logic [bbr_pkg::ChanW-1:0] green_in;
  logic [bbr_pkg::ChanW-1:0] red_in;

  modport source (output valid, output frame_start, output blue_in, output green_in,
                  output red_in, input ready);
  modport sink   (input valid, input frame_start, input blue_in, input green_in,
                  input red_in, output ready);
endinterface

// ----- hdl/bbr_res_if.sv -----
interface bbr_res_if;
  logic                      valid;
  logic                      ready;
  logic [bbr_pkg::ChanW-1:0] blue_out;
  logic [bbr_pkg::ChanW-1:0] green_out;
  logic [bbr_pkg::ChanW-1:0] red_out;
  logic                      row_end;
  logic                      frame_end;

  modport source (output valid, output blue_out, output green_out, output red_out,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input blue_out, input green_out, input red_out,
                  input row_end, input frame_end, output ready);
endinterface

// ----- hdl/box_blur_5x5_rgb_unit.sv -----
// channel   dir  payload                                        transfer when
// pix_i     in   frame_start, blue_in, green_in, red_in         valid & ready
// res_o     out  blue_out, green_out, red_out, row_end,         valid & ready
//                frame_end
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                cfg_we_i high
//
// one pixel per clock while the pipeline advances; after its pixel transfer a result passes
// the line store read, column sum, window sum and reciprocal multiply registers
// the line store is 4 banks of MaxWidth words; a pixel transfer writes one bank, an advance reads all
// all stages advance together while the output register is empty or being taken
// reset clears counters, stage valids and the column sum line; the line store
// is not cleared, it only feeds a result where the frame has already written it
module box_blur_5x5_rgb_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bbr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bbr_pkg::CfgDataW-1:0]      cfg_data_i,
  bbr_pix_if.sink                           pix_i,
  bbr_res_if.source                         res_o
);

  localparam int CalcW = ((bbr_pkg::ImgWidthW > bbr_pkg::ColW) ?
                          bbr_pkg::ImgWidthW : bbr_pkg::ColW) + 1;

  // configuration registers
  logic [bbr_pkg::ImgWidthW-1:0]  img_width_q;
  logic [bbr_pkg::ImgHeightW-1:0] img_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= bbr_pkg::ImgWidthW'(640);
      img_height_q <= bbr_pkg::ImgHeightW'(480);
    end else if (cfg_we_i) begin
      case (bbr_pkg::cfg_reg_e'(cfg_idx_i))
        bbr_pkg::REG_IMAGE_WIDTH:  img_width_q  <= cfg_data_i[bbr_pkg::ImgWidthW-1:0];
        bbr_pkg::REG_IMAGE_HEIGHT: img_height_q <= cfg_data_i[bbr_pkg::ImgHeightW-1:0];
        default: ;
      endcase
    end
  end

  // effective bounds: width clamped to 5..MaxWidth, height raised to 5
  logic [CalcW-1:0]                 width_ext;
  logic [CalcW-1:0]                 width_eff;
  logic [CalcW-1:0]                 width_m1_ext;
  logic [bbr_pkg::ColW-1:0]         width_m1;
  logic [bbr_pkg::ImgHeightW-1:0]   height_m1;

  always_comb begin
    width_ext = CalcW'(img_width_q);
    if (width_ext < CalcW'(bbr_pkg::MinDim)) begin
      width_eff = CalcW'(bbr_pkg::MinDim);
    end else if (width_ext > CalcW'(bbr_pkg::MaxWidth)) begin
      width_eff = CalcW'(bbr_pkg::MaxWidth);
    end else begin
      width_eff = width_ext;
    end
    width_m1_ext = width_eff - CalcW'(1);
    width_m1     = width_m1_ext[bbr_pkg::ColW-1:0];
    if (img_height_q < bbr_pkg::ImgHeightW'(bbr_pkg::MinDim)) begin
      height_m1 = bbr_pkg::ImgHeightW'(bbr_pkg::MinDim - 1);
    end else begin
      height_m1 = img_height_q - bbr_pkg::ImgHeightW'(1);
    end
  end

  // whole pipeline moves while the output register can take a result
  logic adv;
  logic pix_xfer;
  logic out_valid_q;

  assign adv         = !out_valid_q || res_o.ready;
  assign pix_i.ready = adv;
  assign pix_xfer    = pix_i.valid && adv;

  // raster position of the incoming pixel
  logic [bbr_pkg::ColW-1:0]       col_q, col_d;
  logic [bbr_pkg::ImgHeightW-1:0] row_q, row_d;
  logic [bbr_pkg::ColW-1:0]       cur_col;
  logic [bbr_pkg::ImgHeightW-1:0] cur_row;
  logic                           last_col;
  logic                           last_row;
  bbr_pkg::bbr_flag_t             flag0;

  always_comb begin
    // frame start restarts the position, out-of-bound counts act as the last one
    if (pix_i.frame_start) begin
      cur_col = '0;
      cur_row = '0;
    end else begin
      cur_col = (col_q > width_m1)  ? width_m1  : col_q;
      cur_row = (row_q > height_m1) ? height_m1 : row_q;
    end
    last_col = (cur_col == width_m1);
    last_row = (cur_row == height_m1);

    flag0.emit      = (cur_row >= bbr_pkg::ImgHeightW'(bbr_pkg::NumLine)) &&
                      (cur_col >= bbr_pkg::ColW'(bbr_pkg::NumLine));
    flag0.row_end   = last_col;
    flag0.frame_end = last_col && last_row;

    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : cur_row + bbr_pkg::ImgHeightW'(1);
    end else begin
      col_d = cur_col + bbr_pkg::ColW'(1);
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_xfer) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  logic [bbr_pkg::PixW-1:0] pix_in;
  assign pix_in = {pix_i.red_in, pix_i.green_in, pix_i.blue_in};

  // line store: one bank per stored row, written at row mod 4, all read at the column
  logic [bbr_pkg::PixW-1:0] line_rd_q [bbr_pkg::NumLine];

  for (genvar b = 0; b < bbr_pkg::NumLine; b++) begin : g_line
    logic [bbr_pkg::PixW-1:0] line_mem [bbr_pkg::MaxWidth];

    always_ff @(posedge clk_i) begin
      if (pix_xfer && (cur_row[1:0] == 2'(b))) begin
        line_mem[cur_col] <= pix_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        line_rd_q[b] <= line_mem[cur_col];
      end
    end
  end

  // stage 1: current pixel beside the four stored rows
  logic                     s1_valid_q;
  logic [bbr_pkg::PixW-1:0] s1_pix_q;
  bbr_pkg::bbr_flag_t       s1_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q  <= pix_in;
      s1_flag_q <= flag0;
    end
  end

  // the four stored rows are a permutation of the banks, so their sum needs no select
  logic [bbr_pkg::NumChan-1:0][bbr_pkg::ColSumW-1:0] new_colsum;

  always_comb begin
    for (int c = 0; c < bbr_pkg::NumChan; c++) begin
      new_colsum[c] = bbr_pkg::ColSumW'(s1_pix_q[c*bbr_pkg::ChanW +: bbr_pkg::ChanW]);
      for (int b = 0; b < bbr_pkg::NumLine; b++) begin
        new_colsum[c] = new_colsum[c] +
                        bbr_pkg::ColSumW'(line_rd_q[b][c*bbr_pkg::ChanW +: bbr_pkg::ChanW]);
      end
    end
  end

  // stage 2: column sum line, the 5x5 window in summed form
  logic [bbr_pkg::NumChan-1:0][bbr_pkg::ColSumW-1:0] colsum_q [bbr_pkg::WinN];
  logic                                              s2_valid_q;
  bbr_pkg::bbr_flag_t                                s2_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      for (int j = 0; j < bbr_pkg::WinN; j++) begin
        colsum_q[j] <= '0;
      end
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        for (int j = 0; j < bbr_pkg::WinN - 1; j++) begin
          colsum_q[j] <= colsum_q[j+1];
        end
        colsum_q[bbr_pkg::WinN-1] <= new_colsum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_flag_q <= s1_flag_q;
    end
  end

  // stage 3: window sum plus rounding offset
  logic [bbr_pkg::NumChan-1:0][bbr_pkg::SumW-1:0] sum_d, sum_q;
  logic                                           s3_valid_q;
  bbr_pkg::bbr_flag_t                             s3_flag_q;

  always_comb begin
    for (int c = 0; c < bbr_pkg::NumChan; c++) begin
      sum_d[c] = bbr_pkg::SumW'(bbr_pkg::RoundAdd);
      for (int j = 0; j < bbr_pkg::WinN; j++) begin
        sum_d[c] = sum_d[c] + bbr_pkg::SumW'(colsum_q[j][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q && s2_flag_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q     <= sum_d;
      s3_flag_q <= s2_flag_q;
    end
  end

  // stage 4: divide by 25 through the reciprocal, into the output register
  logic [bbr_pkg::NumChan-1:0][bbr_pkg::ProdW-1:0] prod;
  logic [bbr_pkg::NumChan-1:0][bbr_pkg::ChanW-1:0] mean_d, mean_q;
  bbr_pkg::bbr_flag_t                              out_flag_q;

  always_comb begin
    for (int c = 0; c < bbr_pkg::NumChan; c++) begin
      prod[c]   = bbr_pkg::ProdW'(sum_q[c]) *
                  bbr_pkg::ProdW'(bbr_pkg::RecipMul);
      mean_d[c] = prod[c][bbr_pkg::RecipShift +: bbr_pkg::ChanW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mean_q     <= mean_d;
      out_flag_q <= s3_flag_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.blue_out  = mean_q[0];
  assign res_o.green_out = mean_q[1];
  assign res_o.red_out   = mean_q[2];
  assign res_o.row_end   = out_flag_q.row_end;
  assign res_o.frame_end = out_flag_q.frame_end;

  // checks
  a_frame_end_on_row_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_end) |-> res_o.row_end)
    else $error("frame end without row end");

  a_xfer_fills_stage1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_xfer |=> s1_valid_q)
    else $error("transferred pixel lost before stage 1");

  a_result_reaches_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s3_valid_q) |=> res_o.valid)
    else $error("window result did not reach the output register");

  a_emit_needs_position : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_xfer && flag0.emit) |-> (cur_col >= bbr_pkg::ColW'(bbr_pkg::NumLine)))
    else $error("result flagged inside the left border");

endmodule
